FILE: rtl/core/mme_pkg.sv
`timescale 1ns / 1ps
package mme_pkg;

	localparam int ANGLE_FRAC_BITS = 16;
	localparam int CORDIC_STEPS    = 20;
	localparam int Q_BITS          = 30;

	// Square-root unit: 56-bit radicand, one result bit per stage.
	localparam int SQ_IN_W  = 56;
	localparam int SQ_LAT   = SQ_IN_W / 2;
	localparam int SQ_WK_W  = SQ_IN_W + 1;

	// CORDIC working width, signed.
	localparam int CW = 34;

	localparam logic signed [CW-1:0] Q_PI        = 34'sd3373259426;
	localparam logic signed [CW-1:0] Q_HALF_PI   = 34'sd1686629713;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [29:0] EX_MAX = 30'sd8388607;
	localparam logic signed [29:0] EX_MIN = -30'sd8388608;

	typedef enum logic [2:0] {
		REG_BEAM_KE     = 3'd0,
		REG_BEAM_MASS   = 3'd1,
		REG_TARGET_MASS = 3'd2,
		REG_EJECT_MASS  = 3'd3,
		REG_RECOIL_MASS = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [19:0] ejectile_energy;
		logic [17:0] scatter_angle;
	} item_t;

	typedef struct packed {
		logic signed [23:0] excitation;
		logic               valid_res;
	} result_t;

	function automatic logic signed [CW-1:0] cordic_atan(input int i);
		logic signed [CW-1:0] a;
		begin
			case (i)
				0:  a = 34'sd843314857;
				1:  a = 34'sd497837829;
				2:  a = 34'sd263043837;
				3:  a = 34'sd133525159;
				4:  a = 34'sd67021687;
				5:  a = 34'sd33543516;
				6:  a = 34'sd16775851;
				7:  a = 34'sd8388437;
				8:  a = 34'sd4194283;
				9:  a = 34'sd2097149;
				default: a = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
			endcase
			return a;
		end
	endfunction

endpackage

FILE: rtl/core/mme_isqrt.sv
`timescale 1ns / 1ps
module mme_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [mme_pkg::SQ_IN_W-1:0] radicand,
	output logic                        out_vld,
	output logic [mme_pkg::SQ_LAT-1:0]  root
);
	import mme_pkg::*;

	logic [SQ_WK_W-1:0] rem_s  [0:SQ_LAT];
	logic [SQ_WK_W-1:0] root_s [0:SQ_LAT];
	logic               vld_s  [0:SQ_LAT];

	assign rem_s[0]  = {1'b0, radicand};
	assign root_s[0] = '0;
	assign vld_s[0]  = in_vld;

	// Restoring square root: stage g settles the result bit of weight 2^(SQ_LAT-1-g).
	for (genvar g = 0; g < SQ_LAT; g++) begin : g_step
		localparam logic [SQ_WK_W-1:0] BIT = SQ_WK_W'(1) << (2 * (SQ_LAT - 1 - g));
		logic [SQ_WK_W-1:0] trial;
		assign trial = root_s[g] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_s[g] >= trial) begin
				rem_s[g+1]  <= rem_s[g] - trial;
				root_s[g+1] <= (root_s[g] >> 1) + BIT;
			end else begin
				rem_s[g+1]  <= rem_s[g];
				root_s[g+1] <= root_s[g] >> 1;
			end
		end
	end

	assign out_vld = vld_s[SQ_LAT];
	assign root    = root_s[SQ_LAT][SQ_LAT-1:0];

endmodule

FILE: rtl/core/mme_cordic.sv
`timescale 1ns / 1ps
module mme_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic signed [mme_pkg::CW-1:0] angle,
	output logic                          out_vld,
	output logic signed [mme_pkg::CW-1:0] cosine
);
	import mme_pkg::*;

	logic signed [CW-1:0] x_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] y_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] z_s [0:CORDIC_STEPS];
	logic                 vld_s [0:CORDIC_STEPS];

	assign x_s[0]   = CORDIC_GAIN;
	assign y_s[0]   = '0;
	assign z_s[0]   = angle;
	assign vld_s[0] = in_vld;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
		localparam logic signed [CW-1:0] ATAN = cordic_atan(g);
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[g] >>> g;
		assign dy = x_s[g] >>> g;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (!z_s[g][CW-1]) begin
				x_s[g+1] <= x_s[g] - dx;
				y_s[g+1] <= y_s[g] + dy;
				z_s[g+1] <= z_s[g] - ATAN;
			end else begin
				x_s[g+1] <= x_s[g] + dx;
				y_s[g+1] <= y_s[g] - dy;
				z_s[g+1] <= z_s[g] + ATAN;
			end
		end
	end

	assign out_vld = vld_s[CORDIC_STEPS];
	assign cosine  = x_s[CORDIC_STEPS];

endmodule

FILE: rtl/core/missing_mass_excitation.sv
`timescale 1ns / 1ps
// Channel  Signals                                   Direction  Handshake
// input    start, busy, item                         in         start & !busy
// result   done, result                              out        done, one cycle
// config   cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid & cfg_ready
//
// One word is taken every cycle; busy stays low and cfg_ready stays high.
// Each word passes in order through the input and radicand
// registers, two momentum square roots (28 stages), the CORDIC cosine (20 stages),
// four product and sum stages, the recoil-mass square root (28 stages) and the
// output register.
// Reset clears the valid bits and loads the default masses and beam energy.
// The result side cannot stall, so the pipeline never holds.
module missing_mass_excitation (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mme_pkg::item_t   item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [25:0]      cfg_data,
	output logic             done,
	output mme_pkg::result_t result
);
	import mme_pkg::*;

	typedef struct packed {
		logic [26:0]          e1;
		logic [26:0]          e3;
		logic signed [CW-1:0] z;
		logic                 flip;
		logic [24:0]          p1;
		logic [23:0]          p3;
	} side_t;

	localparam int PIPE_LAT = 7 + 2 * SQ_LAT + CORDIC_STEPS;

	logic [21:0] kb_q;
	logic [25:0] m1_q, m2_q, m3_q, m4g_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kb_q  <= 22'd196608;
			m1_q  <= 26'd15275619;
			m2_q  <= 26'd961314;
			m3_q  <= 26'd1921151;
			m4g_q <= 26'd14317858;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BEAM_KE:     kb_q  <= cfg_data[21:0];
				REG_BEAM_MASS:   m1_q  <= cfg_data;
				REG_TARGET_MASS: m2_q  <= cfg_data;
				REG_EJECT_MASS:  m3_q  <= cfg_data;
				REG_RECOIL_MASS: m4g_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input capture.
	item_t item_s1;
	logic  vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
	end

	// Energies, momentum radicands and the folded angle.
	logic signed [CW-1:0] th_full;
	logic [49:0]          arg1_s2;
	logic [47:0]          arg3_s2;
	logic                 vld_s2;
	side_t                side_s [0:SQ_LAT];

	assign th_full = CW'(item_s1.scatter_angle) <<< (Q_BITS - ANGLE_FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s[0].e1 <= 27'(kb_q) + 27'(m1_q);
		side_s[0].e3 <= 27'(item_s1.ejectile_energy) + 27'(m3_q);
		side_s[0].p1 <= '0;
		side_s[0].p3 <= '0;
		arg1_s2 <= 50'(kb_q) * 50'(28'(kb_q) + {1'b0, m1_q, 1'b0});
		arg3_s2 <= 48'(item_s1.ejectile_energy)
			* 48'(28'(item_s1.ejectile_energy) + {1'b0, m3_q, 1'b0});
		if (th_full <= Q_HALF_PI) begin
			side_s[0].z    <= th_full;
			side_s[0].flip <= 1'b0;
		end else begin
			side_s[0].z    <= Q_PI - th_full;
			side_s[0].flip <= 1'b1;
		end
	end

	for (genvar g = 0; g < SQ_LAT; g++) begin : g_side_sq
		always_ff @(posedge clk) begin
			side_s[g+1] <= side_s[g];
		end
	end

	// Momenta.
	logic              p1_vld, p3_vld;
	logic [SQ_LAT-1:0] p1_root, p3_root;

	mme_isqrt u_sqrt_p1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.radicand (SQ_IN_W'(arg1_s2)),
		.out_vld  (p1_vld),
		.root     (p1_root)
	);

	mme_isqrt u_sqrt_p3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.radicand (SQ_IN_W'(arg3_s2)),
		.out_vld  (p3_vld),
		.root     (p3_root)
	);

	// Cosine, with the momenta riding alongside.
	side_t                side_c [0:CORDIC_STEPS];
	logic                 cos_vld;
	logic signed [CW-1:0] cos_x;

	always_comb begin
		side_c[0]    = side_s[SQ_LAT];
		side_c[0].p1 = p1_root[24:0];
		side_c[0].p3 = p3_root[23:0];
	end

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_side_cd
		always_ff @(posedge clk) begin
			side_c[g+1] <= side_c[g];
		end
	end

	mme_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (p1_vld && p3_vld),
		.angle   (side_s[SQ_LAT].z),
		.out_vld (cos_vld),
		.cosine  (cos_x)
	);

	// Products of the mass-squared sum.
	side_t sd;
	logic  c_neg;
	assign sd    = side_c[CORDIC_STEPS];
	assign c_neg = sd.flip ? (cos_x > 0) : cos_x[CW-1];

	logic        vld_s3, cneg_s3;
	logic [31:0] absc_s3;
	logic [48:0] p13_s3;
	logic [51:0] mm1_s3, mm2_s3, mm3_s3;
	logic [52:0] m2e1_s3, m2e3_s3;
	logic [53:0] e1e3_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= cos_vld;
		end
	end

	always_ff @(posedge clk) begin
		cneg_s3 <= c_neg;
		absc_s3 <= cos_x[CW-1] ? 32'(-cos_x) : 32'(cos_x);
		p13_s3  <= 49'(sd.p1) * 49'(sd.p3);
		mm1_s3  <= 52'(m1_q) * 52'(m1_q);
		mm2_s3  <= 52'(m2_q) * 52'(m2_q);
		mm3_s3  <= 52'(m3_q) * 52'(m3_q);
		m2e1_s3 <= 53'(m2_q) * 53'(sd.e1);
		m2e3_s3 <= 53'(m2_q) * 53'(sd.e3);
		e1e3_s3 <= 54'(sd.e1) * 54'(sd.e3);
	end

	// Momentum term as two partial products; the fixed sums.
	logic        vld_s4, cneg_s4;
	logic [48:0] ph_s4;
	logic [63:0] pl_s4;
	logic [55:0] pos_s4, neg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		cneg_s4 <= cneg_s3;
		ph_s4   <= 49'(p13_s3[48:32]) * 49'(absc_s3);
		pl_s4   <= 64'(p13_s3[31:0]) * 64'(absc_s3);
		pos_s4  <= 56'(mm1_s3) + 56'(mm2_s3) + 56'(mm3_s3) + {2'b0, m2e1_s3, 1'b0};
		neg_s4  <= {2'b0, m2e3_s3, 1'b0} + {1'b0, e1e3_s3, 1'b0};
	end

	logic [55:0] cterm;
	assign cterm = ((56'(ph_s4) << 2) + 56'(pl_s4 >> Q_BITS)) << 1;

	logic        vld_s5;
	logic [56:0] pos_s5, neg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		pos_s5 <= cneg_s4 ? 57'(pos_s4) : 57'(pos_s4) + 57'(cterm);
		neg_s5 <= cneg_s4 ? 57'(neg_s4) + 57'(cterm) : 57'(neg_s4);
	end

	logic        vld_s6;
	logic        bad_s6;
	logic [55:0] diff_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		bad_s6  <= (pos_s5 < neg_s5) || (m2_q == '0);
		diff_s6 <= 56'(pos_s5 - neg_s5);
	end

	// Recoil mass.
	logic              bad_d [0:SQ_LAT];
	logic              m4_vld;
	logic [SQ_LAT-1:0] m4_root;

	assign bad_d[0] = bad_s6;
	for (genvar g = 0; g < SQ_LAT; g++) begin : g_bad
		always_ff @(posedge clk) begin
			bad_d[g+1] <= bad_d[g];
		end
	end

	mme_isqrt u_sqrt_m4 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s6),
		.radicand (diff_s6),
		.out_vld  (m4_vld),
		.root     (m4_root)
	);

	logic signed [29:0] ex_raw;
	logic signed [23:0] ex_sat;
	assign ex_raw = $signed({2'b0, m4_root}) - $signed({4'b0, m4g_q});

	always_comb begin
		if (ex_raw > EX_MAX) begin
			ex_sat = 24'(EX_MAX);
		end else if (ex_raw < EX_MIN) begin
			ex_sat = 24'(EX_MIN);
		end else begin
			ex_sat = 24'(ex_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= m4_vld;
		end
	end

	always_ff @(posedge clk) begin
		result.valid_res  <= !bad_d[SQ_LAT];
		result.excitation <= bad_d[SQ_LAT] ? '0 : ex_sat;
	end

	// A rejected word reports zero excitation.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.valid_res |-> result.excitation == '0)
		else $error("invalid result carries nonzero excitation");

	// Every accepted word comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_LAT done)
		else $error("result strobe missing at pipeline latency");

	// No strobe without a word accepted at the matching edge.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(arst_n, PIPE_LAT) |-> $past(start && !busy, PIPE_LAT))
		else $error("result strobe without a matching input word");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import mme_pkg::*;

	localparam int LATENCY   = 83;
	localparam int N_RANDOM  = 1500;
	localparam int WDOG_MAX  = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [25:0] cfg_data;
	logic done;
	result_t result;

	missing_mass_excitation i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .result(result)
	);

	// Predictor's copy of the registers.
	logic [21:0] kb_reg;
	logic [25:0] m1_reg, m2_reg, m3_reg, mg_reg;

	result_t pending_q[$];
	int errors;
	int wdog;
	logic quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		begin
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		end
	endfunction

	function automatic longint asr_floor(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint cos_q30(input longint z);
		longint x, y, dx, dy, a;
		begin
			x = 652032874;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
				dx = asr_floor(y, i);
				dy = asr_floor(x, i);
				a = (i < 10) ? longint'(cordic_atan(i)) : ((i < 31) ? (64'sd1 <<< (30 - i)) : 0);
				if (z >= 0) begin
					x = x - dx; y = y + dy; z = z - a;
				end else begin
					x = x + dx; y = y - dy; z = z + a;
				end
			end
			return x;
		end
	endfunction

	function automatic result_t excitation_of(input item_t it);
		longint unsigned ke, kb, m1, m2, m3, e1, e3, p1, p3, pos, neg, cterm, m4, prod, ac;
		longint th, z, c, ex;
		logic flip;
		result_t r;
		begin
			ke = it.ejectile_energy;
			kb = kb_reg; m1 = m1_reg; m2 = m2_reg; m3 = m3_reg;
			e1 = kb + m1; e3 = ke + m3;
			p1 = int_sqrt(kb * (kb + 2 * m1));
			p3 = int_sqrt(ke * (ke + 2 * m3));
			th = longint'(it.scatter_angle) <<< (30 - ANGLE_FRAC_BITS);
			flip = 1'b0;
			if (th <= 1686629713) z = th;
			else begin
				z = 64'sd3373259426 - th;
				flip = 1'b1;
			end
			c = cos_q30(z);
			if (flip) c = -c;
			ac = (c < 0) ? -c : c;
			prod = p1 * p3;
			cterm = 2 * ((((prod >> 32) * ac) << 2) + (((prod & 64'hFFFFFFFF) * ac) >> 30));
			pos = m1 * m1 + m2 * m2 + m3 * m3 + 2 * m2 * e1;
			neg = 2 * m2 * e3 + 2 * e1 * e3;
			if (c < 0) neg = neg + cterm;
			else pos = pos + cterm;
			if (m2 == 0 || pos < neg) begin
				r.excitation = '0;
				r.valid_res = 1'b0;
			end else begin
				m4 = int_sqrt(pos - neg);
				ex = longint'(m4) - longint'(mg_reg);
				if (ex > 8388607) ex = 8388607;
				if (ex < -8388608) ex = -8388608;
				r.excitation = ex[23:0];
				r.valid_res = 1'b1;
			end
			return r;
		end
	endfunction

	// Result checker and watchdog.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if ((start && !busy) || done) wdog <= 0;
			else wdog <= wdog + 1;
			if (done) begin
				if (pending_q.size() == 0) begin
					errors = errors + 1;
					if (errors <= 10) $display("unexpected word %h", result);
				end else begin
					want = pending_q.pop_front();
					if (want.excitation !== result.excitation ||
						want.valid_res !== result.valid_res) begin
						errors = errors + 1;
						if (errors <= 10)
							$display("mismatch: exp ex=%0d v=%b got ex=%0d v=%b",
								want.excitation, want.valid_res,
								result.excitation, result.valid_res);
					end
				end
			end
			if (wdog >= WDOG_MAX) begin
				$display("FAIL missing_mass_excitation");
				$finish;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [25:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BEAM_KE:     kb_reg = val[21:0];
			REG_BEAM_MASS:   m1_reg = val;
			REG_TARGET_MASS: m2_reg = val;
			REG_EJECT_MASS:  m3_reg = val;
			REG_RECOIL_MASS: mg_reg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stops sending and waits until every word has come back.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		item = '{ejectile_energy: 20'($urandom), scatter_angle: 18'($urandom)};
		while (pending_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// Sends one word; the expected result is queued at the accepting edge.
	// start stays high afterwards so that the next word can follow at once.
	task automatic send_word(input item_t it, input logic idle_ok);
		result_t want;
		@(negedge clk);
		while (idle_ok && !quiet && $urandom_range(99) < 6) begin
			start = 1'b0;
			item = '{ejectile_energy: 20'($urandom), scatter_angle: 18'($urandom)};
			@(negedge clk);
		end
		start = 1'b1;
		item = it;
		@(posedge clk);
		while (busy) @(posedge clk);
		want = excitation_of(it);
		pending_q.push_back(want);
	endtask

	task automatic send_checked(input item_t it, input result_t typed);
		result_t want;
		want = excitation_of(it);
		if (want !== typed) begin
			errors = errors + 1;
			if (errors <= 10) $display("table row disagrees: %h vs %h", typed, want);
		end
		send_word(it, 1'b0);
	endtask

	task automatic random_config();
		write_reg(REG_BEAM_KE, 26'($urandom_range(4194303)));
		write_reg(REG_BEAM_MASS, 26'($urandom_range(67108863)));
		write_reg(REG_TARGET_MASS, 26'($urandom_range(67108863, 1)));
		write_reg(REG_EJECT_MASS, 26'($urandom_range(67108863)));
		write_reg(REG_RECOIL_MASS, 26'($urandom_range(67108863)));
	endtask

	item_t stim_tab[16];
	item_t it;

	initial begin
		errors = 0;
		wdog = 0;
		quiet = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BEAM_KE;
		cfg_data = '0;
		kb_reg = 22'd196608; m1_reg = 26'd15275619; m2_reg = 26'd961314;
		m3_reg = 26'd1921151; mg_reg = 26'd14317858;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		stim_tab[0] = '{20'd0, 18'd0};
		stim_tab[1] = '{20'd1048575, 18'd0};
		stim_tab[2] = '{20'd0, 18'd205887};
		stim_tab[3] = '{20'd1048575, 18'd205887};
		stim_tab[4] = '{20'd1048575, 18'd262143};
		stim_tab[5] = '{20'd20480, 18'd102943};
		stim_tab[6] = '{20'd20480, 18'd102944};
		stim_tab[7] = '{20'd51200, 18'd34315};
		stim_tab[8] = '{20'd524288, 18'd131072};
		stim_tab[9] = '{20'd1, 18'd1};
		for (int i = 0; i < 10; i++) send_word(stim_tab[i], 1'b0);
		drain();

		// Zero target mass is undefined: the word comes back zero and not valid.
		write_reg(REG_TARGET_MASS, 26'd0);
		send_checked('{20'd1000, 18'd5000}, '{24'sd0, 1'b0});
		drain();
		// Huge ejectile energy with light masses gives a negative mass squared.
		write_reg(REG_TARGET_MASS, 26'd1);
		write_reg(REG_BEAM_KE, 22'd0);
		write_reg(REG_BEAM_MASS, 26'd0);
		write_reg(REG_EJECT_MASS, 26'd0);
		write_reg(REG_RECOIL_MASS, 26'd0);
		send_checked('{20'd1048575, 18'd0}, '{24'sd0, 1'b0});
		drain();
		// Large masses with no recoil offset saturate high.
		write_reg(REG_BEAM_MASS, 26'd67108863);
		write_reg(REG_TARGET_MASS, 26'd67108863);
		send_checked('{20'd0, 18'd0}, '{24'sd8388607, 1'b1});
		drain();
		// Zero masses against a huge ground mass saturate low.
		write_reg(REG_BEAM_MASS, 26'd0);
		write_reg(REG_TARGET_MASS, 26'd1);
		write_reg(REG_RECOIL_MASS, 26'd67108863);
		send_checked('{20'd0, 18'd0}, '{-24'sd8388608, 1'b1});
		drain();
		write_reg(REG_BEAM_KE, 22'd4194303);
		write_reg(REG_BEAM_MASS, 26'd67108863);
		write_reg(REG_EJECT_MASS, 26'd67108863);
		write_reg(REG_RECOIL_MASS, 26'd0);
		for (int i = 0; i < 5; i++) send_word(stim_tab[i], 1'b0);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0) begin
				write_reg(REG_BEAM_KE, 22'd196608);
				write_reg(REG_BEAM_MASS, 26'd15275619);
				write_reg(REG_TARGET_MASS, 26'd961314);
				write_reg(REG_EJECT_MASS, 26'd1921151);
				write_reg(REG_RECOIL_MASS, 26'd14317858);
			end else begin
				random_config();
			end
			quiet = (phase == 2);
			for (int n = 0; n < N_RANDOM / 6; n++) begin
				it.ejectile_energy = ($urandom_range(3) == 0) ? 20'($urandom) :
					20'($urandom_range(204800));
				it.scatter_angle = ($urandom_range(15) == 0) ? 18'($urandom) :
					18'($urandom_range(205887));
				send_word(it, 1'b1);
				// The sender now and then waits for every word to come back.
				if (n == 100) drain();
			end
			drain();
		end

		if (errors == 0 && pending_q.size() == 0)
			$display("PASS missing_mass_excitation");
		else
			$display("FAIL missing_mass_excitation");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/mme_pkg.sv
rtl/core/mme_isqrt.sv
rtl/core/mme_cordic.sv
rtl/core/missing_mass_excitation.sv
tb/tb_top.sv
